// ----- rtl/core/md2_pkg.sv -----
// md2_pkg: shared constants, types and the md2 s-box table for the md2 block core
// no dependencies; used by md2_chain and md2_block_compression

package md2_pkg;

  localparam int ROUNDS      = 18;
  localparam int BLOCK_BYTES = 16;
  localparam int LANES       = 8;                          // bytes chained per cycle
  localparam int ROWS        = (3 * BLOCK_BYTES) / LANES;  // half-rows in the work array
  localparam int ROUND_W     = $clog2(ROUNDS);
  localparam int ROW_W       = $clog2(ROWS);
  localparam int WORD_W      = 8 * LANES;

  localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(ROUNDS - 1);
  localparam logic [ROW_W-1:0]   LAST_ROW   = ROW_W'(ROWS - 1);

  // half-row roles in the work array
  localparam logic [ROW_W-1:0] ROW_STATE_LO = ROW_W'(0);
  localparam logic [ROW_W-1:0] ROW_STATE_HI = ROW_W'(1);
  localparam logic [ROW_W-1:0] ROW_BLOCK_LO = ROW_W'(2);
  localparam logic [ROW_W-1:0] ROW_BLOCK_HI = ROW_W'(3);
  localparam logic [ROW_W-1:0] ROW_MIX_LO   = ROW_W'(4);
  localparam logic [ROW_W-1:0] ROW_MIX_HI   = ROW_W'(5);

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [7:0]        byte_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  localparam byte_t SBOX [256] = '{
    8'd41, 8'd46, 8'd67, 8'd201, 8'd162, 8'd216, 8'd124, 8'd1, 8'd61, 8'd54, 8'd84, 8'd161,
    8'd236, 8'd240, 8'd6, 8'd19, 8'd98, 8'd167, 8'd5, 8'd243, 8'd192, 8'd199, 8'd115,
    8'd140, 8'd152, 8'd147, 8'd43, 8'd217, 8'd188, 8'd76, 8'd130, 8'd202, 8'd30, 8'd155,
    8'd87, 8'd60, 8'd253, 8'd212, 8'd224, 8'd22, 8'd103, 8'd66, 8'd111, 8'd24, 8'd138,
    8'd23, 8'd229, 8'd18, 8'd190, 8'd78, 8'd196, 8'd214, 8'd218, 8'd158, 8'd222, 8'd73,
    8'd160, 8'd251, 8'd245, 8'd142, 8'd187, 8'd47, 8'd238, 8'd122, 8'd169, 8'd104,
    8'd121, 8'd145, 8'd21, 8'd178, 8'd7, 8'd63, 8'd148, 8'd194, 8'd16, 8'd137, 8'd11,
    8'd34, 8'd95, 8'd33, 8'd128, 8'd127, 8'd93, 8'd154, 8'd90, 8'd144, 8'd50, 8'd39,
    8'd53, 8'd62, 8'd204, 8'd231, 8'd191, 8'd247, 8'd151, 8'd3, 8'd255, 8'd25, 8'd48,
    8'd179, 8'd72, 8'd165, 8'd181, 8'd209, 8'd215, 8'd94, 8'd146, 8'd42, 8'd172, 8'd86,
    8'd170, 8'd198, 8'd79, 8'd184, 8'd56, 8'd210, 8'd150, 8'd164, 8'd125, 8'd182,
    8'd118, 8'd252, 8'd107, 8'd226, 8'd156, 8'd116, 8'd4, 8'd241, 8'd69, 8'd157, 8'd112,
    8'd89, 8'd100, 8'd113, 8'd135, 8'd32, 8'd134, 8'd91, 8'd207, 8'd101, 8'd230, 8'd45,
    8'd168, 8'd2, 8'd27, 8'd96, 8'd37, 8'd173, 8'd174, 8'd176, 8'd185, 8'd246, 8'd28,
    8'd70, 8'd97, 8'd105, 8'd52, 8'd64, 8'd126, 8'd15, 8'd85, 8'd71, 8'd163, 8'd35,
    8'd221, 8'd81, 8'd175, 8'd58, 8'd195, 8'd92, 8'd249, 8'd206, 8'd186, 8'd197, 8'd234,
    8'd38, 8'd44, 8'd83, 8'd13, 8'd110, 8'd133, 8'd40, 8'd132, 8'd9, 8'd211, 8'd223,
    8'd205, 8'd244, 8'd65, 8'd129, 8'd77, 8'd82, 8'd106, 8'd220, 8'd55, 8'd200, 8'd108,
    8'd193, 8'd171, 8'd250, 8'd36, 8'd225, 8'd123, 8'd8, 8'd12, 8'd189, 8'd177, 8'd74,
    8'd120, 8'd136, 8'd149, 8'd139, 8'd227, 8'd99, 8'd232, 8'd109, 8'd233, 8'd203,
    8'd213, 8'd254, 8'd59, 8'd0, 8'd29, 8'd57, 8'd242, 8'd239, 8'd183, 8'd14, 8'd102,
    8'd88, 8'd208, 8'd228, 8'd166, 8'd119, 8'd114, 8'd248, 8'd235, 8'd117, 8'd75, 8'd10,
    8'd49, 8'd68, 8'd80, 8'd180, 8'd143, 8'd237, 8'd31, 8'd26, 8'd219, 8'd153, 8'd141,
    8'd51, 8'd159, 8'd17, 8'd131, 8'd20
  };

endpackage

// ----- rtl/core/md2_in_if.sv -----
// md2_in_if: input channel carrying one message block beat
// depends on nothing

interface md2_in_if;
  logic        valid;
  logic        ready;
  logic        start_req;
  logic [63:0] block_low;
  logic [63:0] block_high;
  logic        last_block;

  modport source (output valid, start_req, block_low, block_high, last_block, input ready);
  modport sink   (input valid, start_req, block_low, block_high, last_block, output ready);
endinterface

// ----- rtl/core/md2_out_if.sv -----
// md2_out_if: output channel carrying one updated hash state beat
// depends on nothing

interface md2_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] state_low;
  logic [63:0] state_high;
  logic        final_out;

  modport source (output valid, state_low, state_high, final_out, input ready);
  modport sink   (input valid, state_low, state_high, final_out, output ready);
endinterface

// ----- rtl/core/md2_chain.sv -----
// md2_chain: shared s-box chaining unit, runs the md2 chain over one half-row
// depends on md2_pkg (sbox table, word width)

module md2_chain (
  input  md2_pkg::word_t row_in,
  input  md2_pkg::byte_t t_in,
  output md2_pkg::word_t row_out,
  output md2_pkg::byte_t t_out
);

  md2_pkg::byte_t link [md2_pkg::LANES+1];

  // each byte is xored with sbox[t], and that byte becomes the next t
  always_comb begin
    link[0] = t_in;
    for (int i = 0; i < md2_pkg::LANES; i++) begin
      link[i+1] = row_in[8*i +: 8] ^ md2_pkg::SBOX[link[i]];
      row_out[8*i +: 8] = link[i+1];
    end
    t_out = link[md2_pkg::LANES];
  end

endmodule

// ----- rtl/core/md2_block_compression.sv -----
// md2_block_compression: md2 compression function over a persistent 16-byte hash state
// depends on md2_pkg, md2_in_if, md2_out_if and md2_chain
//
// One 16-byte block is taken per input beat and one updated state is returned per block.
// The 48-byte work array is held as six 8-byte half-rows and a single s-box chaining unit
// processes one half-row per cycle, so a block runs 18 rounds over the six half-rows in the
// round loop and then passes through the done state, which moves the state to the output
// register; with the output free, a new block is taken once the core is back in idle, not
// while one is still in the loop. The chaining unit sets the rate.
// The input is ready only in idle. A finished state may sit in the output register while
// the next block is taken, but a block that finishes while that beat is still unread
// waits in the done state. start_req zeroes the state before its block is mixed in;
// last_block is returned unchanged as final_out.

module md2_block_compression (
  input logic      clk,
  input logic      rst,
  md2_in_if.sink   in,
  md2_out_if.source out
);

  md2_pkg::state_t                    state;
  md2_pkg::word_t                     rows [md2_pkg::ROWS];
  logic [md2_pkg::ROW_W-1:0]          row_idx;
  logic [md2_pkg::ROUND_W-1:0]        round_cnt;
  md2_pkg::byte_t                     t;
  logic                               last_q;
  md2_pkg::word_t                     chain_row;
  md2_pkg::byte_t                     chain_t;
  md2_pkg::word_t                     seed_lo;
  md2_pkg::word_t                     seed_hi;
  logic                               accept;

  assign in.ready = (state == md2_pkg::ST_IDLE);
  assign accept   = in.valid && in.ready;

  // state the block chains from: zero on a start beat
  assign seed_lo = in.start_req ? '0 : rows[md2_pkg::ROW_STATE_LO];
  assign seed_hi = in.start_req ? '0 : rows[md2_pkg::ROW_STATE_HI];

  md2_chain u_chain (
    .row_in  (rows[row_idx]),
    .t_in    (t),
    .row_out (chain_row),
    .t_out   (chain_t)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state                      <= md2_pkg::ST_IDLE;
      rows[md2_pkg::ROW_STATE_LO] <= '0;
      rows[md2_pkg::ROW_STATE_HI] <= '0;
      row_idx                    <= '0;
      round_cnt                  <= '0;
      out.valid                  <= 1'b0;
    end else begin
      // the done state reloads the output register itself
      if (out.valid && out.ready && state != md2_pkg::ST_DONE) begin
        out.valid <= 1'b0;
      end
      unique case (state)
        md2_pkg::ST_IDLE: begin
          if (accept) begin
            rows[md2_pkg::ROW_STATE_LO] <= seed_lo;
            rows[md2_pkg::ROW_STATE_HI] <= seed_hi;
            rows[md2_pkg::ROW_BLOCK_LO] <= in.block_low;
            rows[md2_pkg::ROW_BLOCK_HI] <= in.block_high;
            rows[md2_pkg::ROW_MIX_LO]   <= in.block_low ^ seed_lo;
            rows[md2_pkg::ROW_MIX_HI]   <= in.block_high ^ seed_hi;
            last_q    <= in.last_block;
            t         <= '0;
            row_idx   <= '0;
            round_cnt <= '0;
            state     <= md2_pkg::ST_RUN;
          end
        end
        md2_pkg::ST_RUN: begin
          rows[row_idx] <= chain_row;
          if (row_idx == md2_pkg::LAST_ROW) begin
            row_idx <= '0;
            // end of round: t picks up the round index
            t <= chain_t + 8'(round_cnt);
            if (round_cnt == md2_pkg::LAST_ROUND) begin
              state <= md2_pkg::ST_DONE;
            end else begin
              round_cnt <= round_cnt + md2_pkg::ROUND_W'(1);
            end
          end else begin
            row_idx <= row_idx + md2_pkg::ROW_W'(1);
            t       <= chain_t;
          end
        end
        md2_pkg::ST_DONE: begin
          if (!out.valid || out.ready) begin
            out.state_low  <= rows[md2_pkg::ROW_STATE_LO];
            out.state_high <= rows[md2_pkg::ROW_STATE_HI];
            out.final_out  <= last_q;
            out.valid      <= 1'b1;
            state          <= md2_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= md2_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // a beat taken starts the round loop
  a_accept_runs: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == md2_pkg::ST_RUN)
    else $error("accepted block did not enter round loop");

  // half-row index never runs past the work array
  a_row_range: assert property (@(posedge clk) disable iff (rst)
    row_idx <= md2_pkg::LAST_ROW)
    else $error("half-row index out of range");

  // the last half-row of the last round ends the loop
  a_loop_end: assert property (@(posedge clk) disable iff (rst)
    (state == md2_pkg::ST_RUN && row_idx == md2_pkg::LAST_ROW &&
     round_cnt == md2_pkg::LAST_ROUND) |=> state == md2_pkg::ST_DONE)
    else $error("round loop did not finish after last round");

  // a new result only comes out of the done state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out.valid) |-> $past(state == md2_pkg::ST_DONE))
    else $error("result raised outside done state");

  // round counter stays put mid-round
  a_round_hold: assert property (@(posedge clk) disable iff (rst)
    (state == md2_pkg::ST_RUN && row_idx != md2_pkg::LAST_ROW) |=> $stable(round_cnt))
    else $error("round counter moved mid-round");

endmodule
